// ----- rtl/sidta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sidta_pkg;

	localparam int SIDTA_MAX_DIGITS = 10;
	localparam int VALUE_W          = 32;
	localparam int CHAR_W           = 8;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

	// Classified item handed from front to back
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} sidta_item_t;

endpackage

// ----- rtl/sidta_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_front
// Accepts input items, splits each into sign and unsigned magnitude and
// pushes the result into the queue.
// ----------------------------------------------------------------------------
module sidta_front
	import sidta_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,
	output logic               push_valid,
	input  logic               push_ready,
	output sidta_item_t        push_item
);

	logic neg;

	assign neg        = s_tdata[VALUE_W-1];
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;
	// Two's complement negate; the most negative value maps to its own
	// bit pattern, which read unsigned is the right magnitude
	assign push_item.neg = neg;
	assign push_item.mag = neg ? (~s_tdata + VALUE_W'(1)) : s_tdata;

	a_push_follows_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (push_valid && push_ready))
		else $error("front accepted an item without pushing it");

	a_mag_sign_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_item.mag[VALUE_W-1]) |->
		(push_item.neg && push_item.mag == s_tdata))
		else $error("magnitude has top bit set for a value other than the minimum");

	a_neg_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_item.neg) |-> (push_item.mag != '0))
		else $error("negative value gave zero magnitude");

endmodule

// ----- rtl/sidta_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sidta_queue
	import sidta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  sidta_item_t push_item,
	output logic        pop_valid,
	input  logic        pop_ready,
	output sidta_item_t pop_item
);

	sidta_item_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptrs_track_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && count_q == 2'd0) |=> (pop_item == $past(push_item)))
		else $error("item pushed into empty queue not at head");

endmodule

// ----- rtl/sidta_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_back
// Pulls classified items from the queue, extracts decimal digits one per
// cycle by reciprocal multiplication, then sends the sign and the digits
// most significant first through a registered output.
// ----------------------------------------------------------------------------
module sidta_back
	import sidta_pkg::*;
#(
	parameter int MAX_DIGITS = SIDTA_MAX_DIGITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  sidta_item_t       pop_item,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,
	output logic              m_tlast
);

	// A 32-bit magnitude has at most ten digits
	localparam int DEPTH = (MAX_DIGITS < 10) ? MAX_DIGITS : 10;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [2*VALUE_W-1:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic               neg_q;
	logic [VALUE_W-1:0] mag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   rd_q;
	logic [3:0]         dig_q [DEPTH];

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   rem_full;
	logic [CNT_W-1:0]     cnt_nxt;
	logic                 out_free;
	logic                 out_load;

	// floor(mag / 10) = (mag * 0xCCCCCCCD) >> 35, exact over 32 bits
	assign prod     = {{VALUE_W{1'b0}}, mag_q} * RECIP10;
	assign quot     = {3'b000, prod[2*VALUE_W-1:35]};
	assign rem_full = mag_q - ({quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0});
	assign cnt_nxt  = cnt_q + CNT_W'(1);
	assign out_free = !m_tvalid || m_tready;
	assign out_load = out_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			dig_q[cnt_q[IDX_W-1:0]] <= rem_full[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			cnt_q    <= '0;
			rd_q     <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			// load a new character or hold the one still waiting
			m_tvalid <= out_load || (m_tvalid && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						neg_q   <= pop_item.neg;
						mag_q   <= pop_item.mag;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					mag_q <= quot;
					cnt_q <= cnt_nxt;
					if (quot == '0 || cnt_nxt == CNT_W'(DEPTH)) begin
						rd_q    <= cnt_q[IDX_W-1:0];
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						m_tdata  <= CHAR_MINUS;
						m_tlast  <= 1'b0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata  <= CHAR_ZERO + {4'b0000, dig_q[rd_q]};
						m_tlast  <= (rd_q == '0);
						if (rd_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_q <= rd_q - IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("popped item did not start digit extraction");

	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(DEPTH)))
		else $error("digit count overran buffer");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (CNT_W'(rd_q) < cnt_q))
		else $error("read index beyond stored digits");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata == CHAR_MINUS) |-> !m_tlast)
		else $error("sign character marked as last");

	a_run_ends_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && rd_q == '0) |=> (m_tvalid && m_tlast))
		else $error("final digit not marked as last");

endmodule

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts signed 32-bit integers into runs of decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each input item is one signed 32-bit value; the block answers with its
// decimal text, one character per output item: '-' first for negative
// values, then the digits most significant first, tlast on the final one.
// The front passes each accepted item straight into a two-entry queue, so
// input is taken while the back is busy. The back handles one number at a
// time: it loads the number, extracts the digits in the divide-by-ten loop,
// then sends each character through the single output register, and the
// output stalls with tready.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
	import sidta_pkg::*;
#(
	parameter int MAX_DIGITS = SIDTA_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [CHAR_W-1:0]  m_tdata,  // [7:0] char_code
	output logic               m_tlast
);

	logic        push_valid;
	logic        push_ready;
	sidta_item_t push_item;
	logic        pop_valid;
	logic        pop_ready;
	sidta_item_t pop_item;

	sidta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	sidta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	sidta_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- tb/sidta_text_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_text_checker
// Watches both streams of the decimal text block and checks every character.
// ----------------------------------------------------------------------------
// Each value taken on the input side is turned into the characters it must
// produce: a minus sign for negative values, then the decimal digits most
// significant first, with the final one flagged. Characters leaving the block
// are compared in order with the oldest ones still owed. Mismatches and
// characters that nothing accounts for go into the failure count.
// ----------------------------------------------------------------------------
module sidta_text_checker
	import sidta_pkg::*;
#(
	parameter int MAX_DIGITS = SIDTA_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,  // [31:0] value
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [CHAR_W-1:0]  m_tdata,  // [7:0] char_code
	input  logic               m_tlast,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	text_char_t owed_chars[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// Append the decimal text of one value to the characters still owed
	task automatic push_decimal_text(input logic [VALUE_W-1:0] value);
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digs[10];
		int                 n;
		neg = value[VALUE_W-1];
		mag = neg ? (~value + 32'd1) : value;
		n   = 0;
		// least significant digit first; emitted in reverse below
		do begin
			digs[n] = 4'(mag % 32'd10);
			mag     = mag / 32'd10;
			n++;
		end while (mag != 0 && n < MAX_DIGITS && n < 10);
		if (neg)
			owed_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
		for (int j = n - 1; j >= 0; j--)
			owed_chars.push_back('{code: 8'(CHAR_ZERO + digs[j]), last: (j == 0)});
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				push_decimal_text(s_tdata);
			if (m_tvalid && m_tready) begin
				if (owed_chars.size() == 0) begin
					$error("unexpected character: char_code %0d last_char %0b",
						m_tdata, m_tlast);
					errors++;
				end else begin
					want = owed_chars.pop_front();
					if (m_tdata !== want.code) begin
						$error("char_code: expected %0d, got %0d", want.code, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last_char: expected %0b, got %0b", want.last, m_tlast);
						errors++;
					end
				end
			end
		end
		pending <= owed_chars.size();
	end

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Stimulus and verdict for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
// Sends a directed set of values (zero, single digits, powers of ten, both
// extremes and alternating bit patterns), then random values spread over all
// digit counts and signs. Both sides idle at random, with a stretch of full
// rate, one long output hold that backs the block up, and one pause until all
// text has drained. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;
	import sidta_pkg::*;

	localparam int N_RANDOM    = 192;
	localparam int HOLD_CYCLES = 250;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 30;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [CHAR_W-1:0]  m_tdata;
	logic               m_tlast;

	int errors;
	int pending;
	int idle_cycles;
	bit burst;
	bit hold_req;

	signed_int_to_decimal_ascii_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sidta_text_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: give up when nothing moves on either side for too long
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_signed_int_to_decimal_ascii_top NOT OK");
			$finish;
		end
	end

	task automatic send_value(input logic [VALUE_W-1:0] v, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	// Output side: random stalls, plus one long hold on request
	initial begin : sink
		int stall;
		m_tready = 1'b0;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = burst ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int                 directed[18];
		int                 kind;
		int                 d;
		int                 gap;
		longint             lo;
		longint             hi;
		longint             mag;
		logic [VALUE_W-1:0] v;
		directed = '{0, 1, -1, 9, -9, 10, 99, -100, 12345, 999999999, 1000000000,
			32'h7FFFFFFF, 32'h80000000, 32'h80000001, -1000000000,
			32'h55555555, 32'hAAAAAAAA, 2000000000};
		burst    = 1'b0;
		hold_req = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_value(directed[i], $urandom_range(0, 12));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 40)
				hold_req = 1'b1;
			burst = (i >= 90 && i < 120);
			if (i == 140) begin
				// drain everything before carrying on
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				v = $urandom;
			end else if (kind <= 7) begin
				d  = $urandom_range(1, 10);
				lo = 1;
				repeat (d - 1) lo = lo * 10;
				hi = (d == 10) ? 64'd2147483647 : lo * 10 - 1;
				mag = lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
				v = $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
			end else if (kind == 8) begin
				v = 32'($signed($urandom_range(0, 40)) - 20);
			end else begin
				v = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 3)
					: 32'h7FFFFFFF - $urandom_range(0, 3);
			end
			gap = (burst || hold_req) ? 0 : $urandom_range(0, 12);
			send_value(v, gap);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("tb_signed_int_to_decimal_ascii_top OK");
		else
			$display("tb_signed_int_to_decimal_ascii_top NOT OK");
		$finish;
	end

endmodule
